### sv/htw_pkg.sv
// shared types, codes and helpers of the timer wheel
package htw_pkg;

  localparam int DEF_NEAR_BITS  = 8;
  localparam int DEF_FAR_BITS   = 6;
  localparam int DEF_MAX_TIMERS = 32;
  localparam int CQ_DEPTH       = 2;
  localparam int OQ_DEPTH       = 2;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_ADJUST = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    K_ADD  = 3'd0,
    K_ADJ  = 3'd1,
    K_REM  = 3'd2,
    K_QRY  = 3'd3,
    K_EXP  = 3'd4,
    K_DONE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_ADD_BAD,
    OP_ADJ,
    OP_REM,
    OP_QRY,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        h_ok;
    logic [4:0]  handle;
    logic [31:0] per;
    logic [31:0] cnt;
    logic [31:0] tag;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic        ok;
    logic [4:0]  handle;
    logic [31:0] tag;
    logic [31:0] count;
    logic        fired;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ADJ1,
    S_ADJ2,
    S_QRY1,
    S_REM_DONE,
    S_DET0,
    S_DET1,
    S_DET2,
    S_DET3,
    S_PLACE,
    S_APP1,
    S_APP2,
    S_TICK,
    S_CAS_START,
    S_CAS_TAKE,
    S_CAS_RD,
    S_CAS_PL,
    S_CAS_STEP,
    S_CAS_NEXT,
    S_EXP_START,
    S_EXP_TAKE,
    S_EXP_RD,
    S_EXP_EV,
    S_EXP_RE,
    S_EXP_STEP,
    S_DONE,
    S_EMIT
  } st_t;

  function automatic res_t mk_res(kind_t k, logic ok, logic [4:0] h, logic [31:0] tag,
                                  logic [31:0] cnt, logic fired, logic last);
    res_t r;
    r.kind   = k;
    r.ok     = ok;
    r.handle = h;
    r.tag    = tag;
    r.count  = cnt;
    r.fired  = fired;
    r.last   = last;
    return r;
  endfunction

endpackage

### sv/hierarchical_timer_wheel.sv
// top level of the hierarchical timer wheel
//
// Commands enter through a queue-style port: an item is taken when push is
// high and full is low. Results leave the same way: while empty is low the
// oldest result sits on the result ports and is taken when pop is high.
// Add, adjust, remove and query each give one reply; a tick gives one expiry
// per firing timer and then a done item, the last result carrying last=1.
// Unknown command codes are taken and give no result.
// A tick first moves down the timers of each bucket that cascades when the
// near index wraps, then walks the timers of the expiring near slot one at
// a time.
// A small command queue lets the intake run ahead of the engine, and a small
// result queue lets the engine finish a result while the previous one waits.
// After reset the slot store is swept empty, one slot per cycle;
// full stays high until it is done.
// When the receiver stalls the engine holds at its next result and the
// command queue fills, after which full rises.
module hierarchical_timer_wheel #(
  parameter int NEAR_BITS  = htw_pkg::DEF_NEAR_BITS,
  parameter int FAR_BITS   = htw_pkg::DEF_FAR_BITS,
  parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         command,
  input  logic [4:0]         timer_handle,
  input  logic signed [31:0] period,
  input  logic signed [31:0] repeat_count,
  input  logic [31:0]        user_tag,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         kind,
  output logic               ok,
  output logic [4:0]         timer_handle_out,
  output logic [31:0]        tag_out,
  output logic signed [31:0] count_out,
  output logic               fired_any,
  output logic               last
);
  import htw_pkg::*;

  cmd_t cq_item;
  res_t eng_item;
  res_t head;
  logic cq_valid, cq_pop, clearing;
  logic oq_full, oq_push;

  htw_front #(
    .MAX_TIMERS(MAX_TIMERS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .command(command),
    .timer_handle(timer_handle),
    .period(period),
    .repeat_count(repeat_count),
    .user_tag(user_tag),
    .hold(clearing),
    .cq_valid(cq_valid),
    .cq_item(cq_item),
    .cq_pop(cq_pop)
  );

  htw_engine #(
    .NEAR_BITS(NEAR_BITS),
    .FAR_BITS(FAR_BITS),
    .MAX_TIMERS(MAX_TIMERS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .cq_valid(cq_valid),
    .cq_item(cq_item),
    .cq_pop(cq_pop),
    .clearing(clearing),
    .oq_full(oq_full),
    .oq_push(oq_push),
    .oq_item(eng_item)
  );

  htw_outq u_outq (
    .clk(clk),
    .rst(rst),
    .wr(oq_push),
    .wr_item(eng_item),
    .full(oq_full),
    .empty(empty),
    .rd(pop),
    .rd_item(head)
  );

  assign kind             = head.kind;
  assign ok               = head.ok;
  assign timer_handle_out = head.handle;
  assign tag_out          = head.tag;
  assign count_out        = head.count;
  assign fired_any        = head.fired;
  assign last             = head.last;

endmodule

### sv/htw_front.sv
// command intake: classifies commands and queues them for the engine
module htw_front #(
  parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       command,
  input  logic [4:0]       timer_handle,
  input  logic [31:0]      period,
  input  logic [31:0]      repeat_count,
  input  logic [31:0]      user_tag,
  input  logic             hold,
  output logic             cq_valid,
  output htw_pkg::cmd_t    cq_item,
  input  logic             cq_pop
);
  import htw_pkg::*;

  localparam int PTRW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;

  cmd_t            q [CQ_DEPTH];
  logic [PTRW-1:0] wp, rp;
  logic [PTRW:0]   cnt;
  cmd_t            item;
  logic            known;
  logic            enq;

  always_comb begin
    item.h_ok   = {27'd0, timer_handle} < 32'(MAX_TIMERS);
    item.handle = timer_handle;
    item.per    = period;
    item.cnt    = repeat_count;
    item.tag    = user_tag;
    known       = 1'b1;
    case (command)
      CMD_ADD:    item.op = (period == 32'd0 || period[31]) ? OP_ADD_BAD : OP_ADD;
      CMD_ADJUST: item.op = OP_ADJ;
      CMD_REMOVE: item.op = OP_REM;
      CMD_QUERY:  item.op = OP_QRY;
      CMD_TICK:   item.op = OP_TICK;
      default: begin
        // unknown codes are taken and dropped
        item.op = OP_TICK;
        known   = 1'b0;
      end
    endcase
  end

  assign full     = (cnt == (PTRW+1)'(CQ_DEPTH)) || hold;
  assign enq      = push && !full && known;
  assign cq_valid = cnt != '0;
  assign cq_item  = q[rp];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (enq) begin
        wp <= (wp == PTRW'(CQ_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (cq_pop) begin
        rp <= (rp == PTRW'(CQ_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (PTRW+1)'(enq) - (PTRW+1)'(cq_pop);
    end
  end

endmodule

### sv/htw_outq.sv
// result queue between the engine and the result ports
module htw_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  htw_pkg::res_t wr_item,
  output logic          full,
  output logic          empty,
  input  logic          rd,
  output htw_pkg::res_t rd_item
);
  import htw_pkg::*;

  localparam int PTRW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;

  res_t            q [OQ_DEPTH];
  logic [PTRW-1:0] wp, rp;
  logic [PTRW:0]   cnt;
  logic            do_rd;

  assign full    = cnt == (PTRW+1)'(OQ_DEPTH);
  assign empty   = cnt == '0;
  assign rd_item = q[rp];
  assign do_rd   = rd && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PTRW'(OQ_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == PTRW'(OQ_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (PTRW+1)'(wr) - (PTRW+1)'(do_rd);
    end
  end

endmodule

### sv/htw_engine.sv
// wheel engine: timer store, slot lists and the command sequencer
module htw_engine #(
  parameter int NEAR_BITS  = htw_pkg::DEF_NEAR_BITS,
  parameter int FAR_BITS   = htw_pkg::DEF_FAR_BITS,
  parameter int MAX_TIMERS = htw_pkg::DEF_MAX_TIMERS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cq_valid,
  input  htw_pkg::cmd_t cq_item,
  output logic          cq_pop,
  output logic          clearing,
  input  logic          oq_full,
  output logic          oq_push,
  output htw_pkg::res_t oq_item
);
  import htw_pkg::*;

  localparam int NEAR_SLOTS = 1 << NEAR_BITS;
  localparam int FAR_SLOTS  = 1 << FAR_BITS;
  localparam int NSLOT      = NEAR_SLOTS + 4 * FAR_SLOTS;
  localparam int SW         = $clog2(NSLOT);
  localparam int IW         = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int PW         = IW + 1;
  localparam int K1         = NEAR_BITS + FAR_BITS;
  localparam int K2         = NEAR_BITS + 2 * FAR_BITS;
  localparam int K3         = NEAR_BITS + 3 * FAR_BITS;
  localparam logic [PW-1:0] NIL = {PW{1'b1}};

  // slot lists: {first, last}, msb of a pointer marks an empty link
  logic [2*PW-1:0] slot_mem [NSLOT];
  logic [SW-1:0]   s_raddr, s_addr_q, s_waddr;
  logic            s_rd, s_we;
  logic [2*PW-1:0] s_wd, s_q;
  logic [PW-1:0]   first_q, last_q;

  // per-timer store
  logic [31:0]   t_exp [MAX_TIMERS];
  logic [31:0]   t_per [MAX_TIMERS];
  logic [31:0]   t_cnt [MAX_TIMERS];
  logic [31:0]   t_tag [MAX_TIMERS];
  logic [PW-1:0] t_nxt [MAX_TIMERS];
  logic [PW-1:0] t_prv [MAX_TIMERS];
  logic [SW-1:0] t_slt [MAX_TIMERS];
  logic          t_rd;
  logic [IW-1:0] t_raddr, t_waddr;
  logic          we_exp, we_per, we_cnt, we_tag, we_nxt, we_prv, we_slt;
  logic [31:0]   wd_exp, wd_per, wd_cnt, wd_tag;
  logic [PW-1:0] wd_nxt, wd_prv;
  logic [SW-1:0] wd_slt;
  logic [31:0]   r_exp, r_per, r_cnt, r_tag;
  logic [PW-1:0] r_nxt, r_prv;
  logic [SW-1:0] r_slt;

  st_t             state, state_next;
  st_t             place_ret, place_ret_next;
  st_t             det_ret, det_ret_next;
  st_t             emit_ret, emit_ret_next;
  logic [IW-1:0]   cur, cur_next;
  logic [IW-1:0]   walk_cur, walk_cur_next;
  logic [IW-1:0]   walk_tail, walk_tail_next;
  logic [31:0]     exp_r, exp_r_next;
  logic [31:0]     ct, ct_next;
  logic [1:0]      lvl, lvl_next;
  logic            fired, fired_next;
  logic            adj_pend, adj_pend_next;
  logic [31:0]     c_per, c_per_next;
  logic [31:0]     c_cnt, c_cnt_next;
  logic [31:0]     c_tag, c_tag_next;
  logic [SW-1:0]   clr_cnt, clr_cnt_next;
  logic [MAX_TIMERS-1:0] alloc, alloc_next;
  logic [MAX_TIMERS-1:0] pend, pend_next;
  res_t            o_item, o_item_next;

  logic [IW-1:0]   free_idx;
  logic            any_free;
  logic [31:0]     delta;
  logic [SW-1:0]   place_slot;
  logic [FAR_BITS-1:0] lvl_idx;
  logic [SW-1:0]   lvl_base;
  logic [IW-1:0]   hidx;
  logic            h_valid;
  logic [31:0]     new_exp;
  logic [31:0]     cnt_dec;
  logic [PW-1:0]   cur_ptr;

  assign first_q  = s_q[2*PW-1:PW];
  assign last_q   = s_q[PW-1:0];
  assign clearing = state == S_CLEAR;
  assign oq_item  = o_item;
  assign s_waddr  = (state == S_CLEAR) ? clr_cnt : s_addr_q;
  assign hidx     = IW'(cq_item.handle);
  assign h_valid  = cq_item.h_ok && alloc[hidx];
  assign new_exp  = ct + c_per;
  assign cnt_dec  = r_cnt[31] ? r_cnt : r_cnt - 32'd1;
  assign cur_ptr  = PW'(cur);

  // lowest free timer
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!alloc[i]) begin
        free_idx = IW'(i);
        any_free = 1'b1;
      end
    end
  end

  // slot choice for a timer expiring at exp_r
  always_comb begin
    delta = exp_r - ct;
    if ((delta >> NEAR_BITS) == 32'd0) begin
      place_slot = SW'(exp_r[NEAR_BITS-1:0]);
    end else if ((delta >> K1) == 32'd0) begin
      place_slot = SW'(NEAR_SLOTS) + SW'(FAR_BITS'(exp_r >> NEAR_BITS));
    end else if ((delta >> K2) == 32'd0) begin
      place_slot = SW'(NEAR_SLOTS + FAR_SLOTS) + SW'(FAR_BITS'(exp_r >> K1));
    end else if ((delta >> K3) == 32'd0) begin
      place_slot = SW'(NEAR_SLOTS + 2 * FAR_SLOTS) + SW'(FAR_BITS'(exp_r >> K2));
    end else if (delta[31]) begin
      // expiry already in the past: lands in the current near slot
      place_slot = SW'(ct[NEAR_BITS-1:0]);
    end else begin
      place_slot = SW'(NEAR_SLOTS + 3 * FAR_SLOTS) + SW'(FAR_BITS'(exp_r >> K3));
    end
  end

  always_comb begin
    case (lvl)
      2'd0: begin
        lvl_idx  = FAR_BITS'(ct >> NEAR_BITS);
        lvl_base = SW'(NEAR_SLOTS);
      end
      2'd1: begin
        lvl_idx  = FAR_BITS'(ct >> K1);
        lvl_base = SW'(NEAR_SLOTS + FAR_SLOTS);
      end
      2'd2: begin
        lvl_idx  = FAR_BITS'(ct >> K2);
        lvl_base = SW'(NEAR_SLOTS + 2 * FAR_SLOTS);
      end
      default: begin
        lvl_idx  = FAR_BITS'(ct >> K3);
        lvl_base = SW'(NEAR_SLOTS + 3 * FAR_SLOTS);
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    place_ret_next = place_ret;
    det_ret_next   = det_ret;
    emit_ret_next  = emit_ret;
    cur_next       = cur;
    walk_cur_next  = walk_cur;
    walk_tail_next = walk_tail;
    exp_r_next     = exp_r;
    ct_next        = ct;
    lvl_next       = lvl;
    fired_next     = fired;
    adj_pend_next  = adj_pend;
    c_per_next     = c_per;
    c_cnt_next     = c_cnt;
    c_tag_next     = c_tag;
    clr_cnt_next   = clr_cnt;
    alloc_next     = alloc;
    pend_next      = pend;
    o_item_next    = o_item;
    cq_pop   = 1'b0;
    oq_push  = 1'b0;
    s_rd     = 1'b0;
    s_raddr  = '0;
    s_we     = 1'b0;
    s_wd     = {NIL, NIL};
    t_rd     = 1'b0;
    t_raddr  = '0;
    t_waddr  = cur;
    we_exp   = 1'b0;
    we_per   = 1'b0;
    we_cnt   = 1'b0;
    we_tag   = 1'b0;
    we_nxt   = 1'b0;
    we_prv   = 1'b0;
    we_slt   = 1'b0;
    wd_exp   = exp_r;
    wd_per   = c_per;
    wd_cnt   = c_cnt;
    wd_tag   = c_tag;
    wd_nxt   = NIL;
    wd_prv   = NIL;
    wd_slt   = s_addr_q;

    case (state)
      S_CLEAR: begin
        s_we         = 1'b1;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == SW'(NSLOT - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cq_valid) begin
          cq_pop        = 1'b1;
          emit_ret_next = S_IDLE;
          c_per_next    = cq_item.per;
          c_cnt_next    = cq_item.cnt;
          c_tag_next    = cq_item.tag;
          case (cq_item.op)
            OP_ADD_BAD: begin
              o_item_next = mk_res(K_ADD, 1'b0, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
              state_next  = S_EMIT;
            end
            OP_ADD: begin
              if (!any_free) begin
                o_item_next = mk_res(K_ADD, 1'b0, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                state_next  = S_EMIT;
              end else begin
                t_waddr              = free_idx;
                we_exp               = 1'b1;
                we_per               = 1'b1;
                we_cnt               = 1'b1;
                we_tag               = 1'b1;
                wd_exp               = ct + cq_item.per;
                wd_per               = cq_item.per;
                wd_cnt               = cq_item.cnt;
                wd_tag               = cq_item.tag;
                alloc_next[free_idx] = 1'b1;
                pend_next[free_idx]  = 1'b0;
                cur_next             = free_idx;
                exp_r_next           = ct + cq_item.per;
                o_item_next    = mk_res(K_ADD, 1'b1, 5'(free_idx), 32'd0, 32'd0, 1'b0, 1'b1);
                place_ret_next = S_EMIT;
                state_next     = S_PLACE;
              end
            end
            OP_ADJ: begin
              if (!h_valid) begin
                o_item_next = mk_res(K_ADJ, 1'b0, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                state_next  = S_EMIT;
              end else begin
                cur_next   = hidx;
                t_rd       = 1'b1;
                t_raddr    = hidx;
                state_next = S_ADJ1;
              end
            end
            OP_REM: begin
              if (!h_valid) begin
                o_item_next = mk_res(K_REM, 1'b0, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                state_next  = S_EMIT;
              end else if (pend[hidx]) begin
                cur_next     = hidx;
                det_ret_next = S_REM_DONE;
                state_next   = S_DET0;
              end else begin
                // not pending: only the count is cleared
                t_waddr     = hidx;
                we_cnt      = 1'b1;
                wd_cnt      = 32'd0;
                o_item_next = mk_res(K_REM, 1'b1, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                state_next  = S_EMIT;
              end
            end
            OP_QRY: begin
              if (!h_valid) begin
                o_item_next = mk_res(K_QRY, 1'b0, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                state_next  = S_EMIT;
              end else begin
                t_rd       = 1'b1;
                t_raddr    = hidx;
                state_next = S_QRY1;
              end
            end
            OP_TICK: begin
              fired_next = 1'b0;
              state_next = S_TICK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_ADJ1: begin
        adj_pend_next = pend[cur];
        o_item_next   = mk_res(K_ADJ, 1'b1, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
        if (pend[cur] && r_exp == new_exp) begin
          state_next = S_EMIT;
        end else if (pend[cur]) begin
          det_ret_next = S_ADJ2;
          state_next   = S_DET0;
        end else begin
          state_next = S_ADJ2;
        end
      end

      S_ADJ2: begin
        we_exp     = 1'b1;
        we_per     = 1'b1;
        we_cnt     = 1'b1;
        we_tag     = c_tag != 32'd0;
        wd_exp     = new_exp;
        exp_r_next = new_exp;
        if (adj_pend) begin
          place_ret_next = S_EMIT;
          state_next     = S_PLACE;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_QRY1: begin
        o_item_next = mk_res(K_QRY, 1'b1, 5'd0, 32'd0, r_cnt, 1'b0, 1'b1);
        state_next  = S_EMIT;
      end

      S_REM_DONE: begin
        alloc_next[cur] = 1'b0;
        o_item_next     = mk_res(K_REM, 1'b1, 5'd0, 32'd0, 32'd0, 1'b0, 1'b1);
        state_next      = S_EMIT;
      end

      S_DET0: begin
        t_rd       = 1'b1;
        t_raddr    = cur;
        state_next = S_DET1;
      end

      S_DET1: begin
        s_rd       = 1'b1;
        s_raddr    = r_slt;
        state_next = S_DET2;
      end

      S_DET2: begin
        s_we    = 1'b1;
        s_wd    = {(r_prv[PW-1] ? r_nxt : first_q), (r_nxt[PW-1] ? r_prv : last_q)};
        t_waddr = IW'(r_prv);
        we_nxt  = !r_prv[PW-1];
        wd_nxt  = r_nxt;
        state_next = S_DET3;
      end

      S_DET3: begin
        t_waddr        = IW'(r_nxt);
        we_prv         = !r_nxt[PW-1];
        wd_prv         = r_prv;
        pend_next[cur] = 1'b0;
        state_next     = det_ret;
      end

      S_PLACE: begin
        s_rd       = 1'b1;
        s_raddr    = place_slot;
        state_next = S_APP1;
      end

      S_APP1: begin
        we_prv         = 1'b1;
        we_nxt         = 1'b1;
        we_slt         = 1'b1;
        wd_prv         = last_q;
        wd_nxt         = NIL;
        wd_slt         = s_addr_q;
        pend_next[cur] = 1'b1;
        s_we           = 1'b1;
        s_wd           = {(last_q[PW-1] ? cur_ptr : first_q), cur_ptr};
        state_next     = last_q[PW-1] ? place_ret : S_APP2;
      end

      S_APP2: begin
        t_waddr    = IW'(last_q);
        we_nxt     = 1'b1;
        wd_nxt     = cur_ptr;
        state_next = place_ret;
      end

      S_TICK: begin
        if (ct[NEAR_BITS-1:0] == '0) begin
          lvl_next   = 2'd0;
          state_next = S_CAS_START;
        end else begin
          state_next = S_EXP_START;
        end
      end

      S_CAS_START: begin
        s_rd       = 1'b1;
        s_raddr    = lvl_base + SW'(lvl_idx);
        state_next = S_CAS_TAKE;
      end

      S_CAS_TAKE: begin
        s_we           = 1'b1;
        walk_cur_next  = IW'(first_q);
        walk_tail_next = IW'(last_q);
        state_next     = first_q[PW-1] ? S_CAS_NEXT : S_CAS_RD;
      end

      S_CAS_RD: begin
        t_rd       = 1'b1;
        t_raddr    = walk_cur;
        state_next = S_CAS_PL;
      end

      S_CAS_PL: begin
        cur_next       = walk_cur;
        exp_r_next     = r_exp;
        place_ret_next = S_CAS_STEP;
        state_next     = S_PLACE;
      end

      S_CAS_STEP: begin
        // stop at the tail seen when the bucket was taken
        if (cur == walk_tail) begin
          state_next = S_CAS_NEXT;
        end else begin
          walk_cur_next = IW'(r_nxt);
          state_next    = S_CAS_RD;
        end
      end

      S_CAS_NEXT: begin
        if (lvl_idx == '0 && lvl != 2'd3) begin
          lvl_next   = lvl + 2'd1;
          state_next = S_CAS_START;
        end else begin
          state_next = S_EXP_START;
        end
      end

      S_EXP_START: begin
        s_rd       = 1'b1;
        s_raddr    = SW'(ct[NEAR_BITS-1:0]);
        state_next = S_EXP_TAKE;
      end

      S_EXP_TAKE: begin
        s_we           = 1'b1;
        walk_cur_next  = IW'(first_q);
        walk_tail_next = IW'(last_q);
        state_next     = first_q[PW-1] ? S_DONE : S_EXP_RD;
      end

      S_EXP_RD: begin
        t_rd       = 1'b1;
        t_raddr    = walk_cur;
        state_next = S_EXP_EV;
      end

      S_EXP_EV: begin
        cur_next            = walk_cur;
        fired_next          = 1'b1;
        pend_next[walk_cur] = 1'b0;
        if (r_cnt == 32'd0) begin
          // exhausted timer is freed without an expiry
          alloc_next[walk_cur] = 1'b0;
          state_next           = S_EXP_STEP;
        end else begin
          t_waddr       = walk_cur;
          we_cnt        = 1'b1;
          wd_cnt        = cnt_dec;
          o_item_next   = mk_res(K_EXP, 1'b1, 5'(walk_cur), r_tag, cnt_dec, 1'b0, 1'b0);
          emit_ret_next = S_EXP_RE;
          state_next    = S_EMIT;
        end
      end

      S_EXP_RE: begin
        if (cnt_dec == 32'd0) begin
          alloc_next[cur] = 1'b0;
          state_next      = S_EXP_STEP;
        end else begin
          we_exp         = 1'b1;
          wd_exp         = ct + 32'd1 + r_per;
          exp_r_next     = ct + 32'd1 + r_per;
          place_ret_next = S_EXP_STEP;
          state_next     = S_PLACE;
        end
      end

      S_EXP_STEP: begin
        if (cur == walk_tail) begin
          state_next = S_DONE;
        end else begin
          walk_cur_next = IW'(r_nxt);
          state_next    = S_EXP_RD;
        end
      end

      S_DONE: begin
        ct_next       = ct + 32'd1;
        o_item_next   = mk_res(K_DONE, 1'b0, 5'd0, 32'd0, 32'd0, fired, 1'b1);
        emit_ret_next = S_IDLE;
        state_next    = S_EMIT;
      end

      S_EMIT: begin
        if (!oq_full) begin
          oq_push    = 1'b1;
          state_next = emit_ret;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      ct      <= '0;
      alloc   <= '0;
      pend    <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      ct      <= ct_next;
      alloc   <= alloc_next;
      pend    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    place_ret <= place_ret_next;
    det_ret   <= det_ret_next;
    emit_ret  <= emit_ret_next;
    cur       <= cur_next;
    walk_cur  <= walk_cur_next;
    walk_tail <= walk_tail_next;
    exp_r     <= exp_r_next;
    lvl       <= lvl_next;
    fired     <= fired_next;
    adj_pend  <= adj_pend_next;
    c_per     <= c_per_next;
    c_cnt     <= c_cnt_next;
    c_tag     <= c_tag_next;
    o_item    <= o_item_next;
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      slot_mem[s_waddr] <= s_wd;
    end
    if (s_rd) begin
      s_q      <= slot_mem[s_raddr];
      s_addr_q <= s_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (we_exp) t_exp[t_waddr] <= wd_exp;
    if (we_per) t_per[t_waddr] <= wd_per;
    if (we_cnt) t_cnt[t_waddr] <= wd_cnt;
    if (we_tag) t_tag[t_waddr] <= wd_tag;
    if (we_nxt) t_nxt[t_waddr] <= wd_nxt;
    if (we_prv) t_prv[t_waddr] <= wd_prv;
    if (we_slt) t_slt[t_waddr] <= wd_slt;
    if (t_rd) begin
      r_exp <= t_exp[t_raddr];
      r_per <= t_per[t_raddr];
      r_cnt <= t_cnt[t_raddr];
      r_tag <= t_tag[t_raddr];
      r_nxt <= t_nxt[t_raddr];
      r_prv <= t_prv[t_raddr];
      r_slt <= t_slt[t_raddr];
    end
  end

`ifndef SYNTHESIS
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cq_pop)
    else $error("command taken during slot clearing");

  a_time_moves_on_done_only: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |=> $stable(ct))
    else $error("time advanced outside tick completion");

  a_pending_is_allocated: assert property (@(posedge clk) disable iff (rst)
    (pend & ~alloc) == '0)
    else $error("pending timer that is not allocated");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (oq_push && oq_item.kind == K_DONE) |-> (oq_item.last && !oq_item.ok))
    else $error("tick done item malformed");
`endif

endmodule
